[src/sha_pkg.sv]
package sha_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       wr_byte;    // write byte into block buffer
    logic [1:0] byte_sel;   // 0 data, 1 pad 0x80, 2 zero, 3 length byte
    logic       comp_start; // load working vars
    logic       comp_round; // run one round
    logic       comp_done;  // add working vars into chaining state
    logic       reset_hash; // back to initial hash values
    logic       shift_out;  // rotate chaining words for output
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] pos;
    logic [5:0] round;
  } stat_t;

  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[src/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream. Each absorb item writes one byte into the block
// buffer; the 64th byte of a block starts a compression (load, 64 rounds at
// one round per cycle, chaining add), during which in_ready is low. A finalize
// item writes the padding one byte per cycle up to the end of the block (with a
// second block when fewer than 8 bytes remain), compresses, then presents the
// eight digest words, word 0 first, one per accepted output item, with
// last_word on word 7; the hasher then returns to the initial hash values.
module sha256_byte_stream_hasher (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_item_t out_data
);
  import sha_pkg::*;

  ctrl_t       ctrl;
  stat_t       stat;
  logic [31:0] word;
  logic [2:0]  index;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_data.mode),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(index),
    .stat(stat), .ctrl(ctrl)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .data_byte(in_data.data_byte),
    .stat(stat), .out_word(word)
  );

  assign out_data.digest_word = word;
  assign out_data.word_index  = index;
  assign out_data.last_word   = (index == 3'd7);

endmodule

[src/sha_datapath.sv]
module sha_datapath (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::ctrl_t ctrl,
  input  logic [7:0]    data_byte,
  output sha_pkg::stat_t stat,
  output logic [31:0]   out_word
);
  import sha_pkg::*;

  logic [31:0] h [8];
  logic [31:0] v [8];
  // schedule window; also serves as the block buffer while bytes arrive
  logic [31:0] w [16];
  logic [63:0] count;
  logic [5:0]  round;
  logic [7:0]  byte_val;
  logic [63:0] bits;
  logic [4:0]  lane_lsb;
  logic [31:0] wt, s0, s1, x15, x2, t1, t2, ep0, ep1, ch, maj;

  // length bytes come from a latched copy so the position counter can move
  logic [63:0] len_sh;

  assign bits     = {count[60:0], 3'b000};
  assign lane_lsb = {~count[1:0], 3'b000};  // big-endian byte lane in the word

  always_comb begin
    case (ctrl.byte_sel)
      SEL_DATA: byte_val = data_byte;
      SEL_PAD:  byte_val = 8'h80;
      SEL_ZERO: byte_val = 8'h00;
      SEL_LEN:  byte_val = len_sh[63:56];
      default:  byte_val = 8'h00;
    endcase
  end

  always_comb begin
    x15 = w[1];
    x2  = w[14];
    s0  = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
    s1  = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
    wt  = w[0];
    ep1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    ep0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + ep1 + ch + ROUND_K[round] + wt;
    t2  = ep0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      round <= '0;
      for (int i = 0; i < 8; i++) h[i] <= IV[i];
    end else begin
      if (ctrl.reset_hash) begin
        count <= '0;
      end else if (ctrl.wr_byte) begin
        count <= count + 64'd1;
      end

      if (ctrl.wr_byte) begin
        if (ctrl.byte_sel == SEL_PAD) begin
          len_sh <= bits;
        end else if (ctrl.byte_sel == SEL_LEN) begin
          len_sh <= {len_sh[55:0], 8'h00};
        end
      end

      if (ctrl.comp_round) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w[0] + s0 + w[9] + s1;
      end else if (ctrl.wr_byte) begin
        w[count[5:2]][lane_lsb +: 8] <= byte_val;
      end

      if (ctrl.comp_start) begin
        round <= '0;
        for (int i = 0; i < 8; i++) v[i] <= h[i];
      end else if (ctrl.comp_round) begin
        round <= round + 6'd1;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      end

      if (ctrl.reset_hash) begin
        for (int i = 0; i < 8; i++) h[i] <= IV[i];
      end else if (ctrl.comp_done) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end else if (ctrl.shift_out) begin
        for (int i = 0; i < 7; i++) h[i] <= h[i+1];
        h[7] <= h[0];
      end
    end
  end

  assign stat.pos   = count[5:0];
  assign stat.round = round;
  assign out_word   = h[0];

endmodule

[src/sha_ctrl.sv]
module sha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_index,
  input  sha_pkg::stat_t   stat,
  output sha_pkg::ctrl_t   ctrl
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic       fin, fin_next;     // finalizing
  logic       last, last_next;   // current block is the final one
  logic [2:0] idx, idx_next;
  logic       acc;

  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_index = idx;

  always_comb begin
    state_next = state;
    fin_next = fin;
    last_next = last;
    idx_next = idx;
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          ctrl.wr_byte = 1'b1;
          if (in_mode) begin
            ctrl.byte_sel = SEL_PAD;
            fin_next = 1'b1;
            // length fits behind the pad byte only below position 56
            last_next = (stat.pos < LEN_POS);
            if (stat.pos == 6'd63) state_next = S_START;
            else state_next = S_PAD;
          end else begin
            ctrl.byte_sel = SEL_DATA;
            if (stat.pos == 6'd63) state_next = S_START;
          end
        end
      end
      S_PAD: begin
        ctrl.wr_byte = 1'b1;
        // length only in the last eight bytes of the final block
        ctrl.byte_sel = (last && stat.pos >= LEN_POS) ? SEL_LEN : SEL_ZERO;
        if (stat.pos == 6'd63) state_next = S_START;
      end
      S_START: begin
        ctrl.comp_start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        ctrl.comp_round = 1'b1;
        if (stat.round == 6'd63) state_next = S_ADD;
      end
      S_ADD: begin
        ctrl.comp_done = 1'b1;
        if (!fin) state_next = S_IDLE;
        else if (last) begin
          idx_next = 3'd0;
          state_next = S_OUT;
        end else begin
          last_next = 1'b1;
          state_next = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          ctrl.shift_out = 1'b1;
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            ctrl.shift_out = 1'b0;
            ctrl.reset_hash = 1'b1;
            fin_next = 1'b0;
            last_next = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin <= 1'b0;
      last <= 1'b0;
      idx <= 3'd0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      last <= last_next;
      idx <= idx_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while emitting");
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> idx == 3'd0) else $error("digest starts mid-way");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> $past(state) == S_ROUND) else $error("bad add entry");

endmodule

[tb/sha256_byte_stream_hasher_tb.sv]
module sha256_byte_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  localparam logic MODE_ABSORB   = 1'b0;
  localparam logic MODE_FINALIZE = 1'b1;
  localparam int   CYCLE_LIMIT   = 400000;
  localparam int   DRAIN_CYCLES  = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  sha256_byte_stream_hasher uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state: chaining words, byte count, block buffer
  logic [31:0] hash_h [8];
  logic [63:0] byte_count;
  logic [7:0]  blk [64];
  out_item_t   digest_q [$];

  int mismatches = 0;
  int cycles = 0;

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
    byte_count = '0;
  endtask

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wr, t1, t2, x15, x2;
    for (int r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        x15 = w[(r-15) & 15];
        x2  = w[(r-2) & 15];
        wr = w[r & 15] + (rotr(x15,7) ^ rotr(x15,18) ^ (x15 >> 3)) + w[(r-7) & 15]
             + (rotr(x2,17) ^ rotr(x2,19) ^ (x2 >> 10));
        w[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4],6) ^ rotr(v[4],11) ^ rotr(v[4],25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
      t2 = (rotr(v[0],2) ^ rotr(v[0],13) ^ rotr(v[0],22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  // work out the digest words an accepted item causes
  task automatic predict_item(in_item_t it);
    int pos;
    logic [63:0] bits;
    out_item_t o;
    pos = int'(byte_count[5:0]);
    if (it.mode == MODE_ABSORB) begin
      blk[pos] = it.data_byte;
      byte_count = byte_count + 64'd1;
      if (pos == 63) compress();
      return;
    end
    bits = byte_count << 3;
    blk[pos++] = 8'h80;
    if (pos > int'(LEN_POS)) begin
      while (pos < 64) blk[pos++] = 8'h00;
      compress();
      pos = 0;
    end
    while (pos < int'(LEN_POS)) blk[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = hash_h[i];
      o.word_index  = 3'(i);
      o.last_word   = (i == 7);
      digest_q = {digest_q, o};
    end
    hash_reset();
  endtask

  // send one item after a random gap; valid stays up until accepted
  task automatic send_item(logic mode, logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, data_byte: b};
    do @(posedge clk); while (!in_ready);
    predict_item('{mode: mode, data_byte: b});
  endtask

  task automatic send_message(int len, bit ff_fill);
    for (int i = 0; i < len; i++)
      send_item(MODE_ABSORB, ff_fill ? 8'hff : 8'($urandom_range(0, 255)));
    send_item(MODE_FINALIZE, 8'($urandom_range(0, 255)));
  endtask

  // sender goes idle and holds until every expected digest word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall per item, compare with oldest expectation
  initial begin
    out_item_t exp_item;
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest item %h", out_data);
      end else begin
        exp_item = digest_q.pop_front();
        if (out_data.digest_word !== exp_item.digest_word ||
            out_data.word_index !== exp_item.word_index ||
            out_data.last_word !== exp_item.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                     exp_item.digest_word, exp_item.word_index, exp_item.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // empty message, single data byte extremes
  task automatic test_short_messages();
    send_message(0, 0);
    send_item(MODE_ABSORB, 8'h00);
    send_item(MODE_FINALIZE, 8'hff);
    send_item(MODE_ABSORB, 8'hff);
    send_item(MODE_FINALIZE, 8'h00);
  endtask

  // padding boundaries: 55 fits, 56 needs an extra block, 64 a full block
  task automatic test_pad_boundaries();
    send_message(55, 1);
    wait_drained();
    send_message(56, 0);
    send_message(64, 1);
  endtask

  // random messages, sent until at least 80 items have gone in
  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 80) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
      send_message(len, 0);
      sent += len + 1;
    end
  endtask

  initial begin
    hash_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_short_messages();
    test_pad_boundaries();
    test_random_messages();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
src/sha_pkg.sv
src/sha_datapath.sv
src/sha_ctrl.sv
src/sha256_byte_stream_hasher.sv
tb/sha256_byte_stream_hasher_tb.sv
